>>> rtl/asd_pkg.sv
package asd_pkg;

	localparam int TIME_WIDTH = 64;

	localparam int ACCEL_W = 29;
	localparam int LTIME_W = 63;
	localparam int CAP_W   = 32;
	localparam int BASE_W  = 63;
	localparam int STAMP_W = 63;

	localparam int X_LSB    = 0;
	localparam int Y_LSB    = X_LSB + ACCEL_W;
	localparam int Z_LSB    = Y_LSB + ACCEL_W;
	localparam int LT_LSB   = Z_LSB + ACCEL_W;
	localparam int CAP_LSB  = LT_LSB + LTIME_W;
	localparam int BASE_LSB = CAP_LSB + CAP_W;
	localparam int IN_BITS  = BASE_LSB + BASE_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((STAMP_W + 7) / 8) * 8;

	localparam int SQ1_W = 2 * ACCEL_W;
	localparam int MAG_W = SQ1_W;

	localparam int LEVEL_W   = 14;
	localparam int COOL_W    = 16;
	localparam int LIN_W     = 28;
	localparam int LVL_SQ_W  = 2 * LIN_W;
	localparam int COOL_US_W = 26;

	localparam longint unsigned SCALE_TO_MICRO   = 10000;
	localparam longint unsigned MICROS_PER_MILLI = 1000;

	localparam logic [LEVEL_W-1:0] IMPACT_RESET = LEVEL_W'(2000);
	localparam logic [LEVEL_W-1:0] LIFT_RESET   = LEVEL_W'(500);
	localparam logic [COOL_W-1:0]  COOL_RESET   = COOL_W'(250);

	localparam longint unsigned IMPACT_LIN = 64'(IMPACT_RESET) * SCALE_TO_MICRO;
	localparam longint unsigned LIFT_LIN   = 64'(LIFT_RESET) * SCALE_TO_MICRO;
	localparam logic [LIN_W-1:0]     IMPACT_LIN_RESET = LIN_W'(IMPACT_LIN);
	localparam logic [LIN_W-1:0]     LIFT_LIN_RESET   = LIN_W'(LIFT_LIN);
	localparam logic [LVL_SQ_W-1:0]  IMPACT_SQ_RESET  = LVL_SQ_W'(IMPACT_LIN * IMPACT_LIN);
	localparam logic [LVL_SQ_W-1:0]  LIFT_SQ_RESET    = LVL_SQ_W'(LIFT_LIN * LIFT_LIN);
	localparam logic [COOL_US_W-1:0] COOL_US_RESET    =
		COOL_US_W'(64'(COOL_RESET) * MICROS_PER_MILLI);

	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_IMPACT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LIFT   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COOL   = 2'd2;

	// power of two: pointers wrap
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [LVL_SQ_W-1:0]  impact_sq;
		logic [LVL_SQ_W-1:0]  lift_sq;
		logic [COOL_US_W-1:0] cool_us;
	} cfg_t;

	typedef struct packed {
		logic [MAG_W-1:0]      mag;
		logic [TIME_WIDTH-1:0] now;
		logic [STAMP_W-1:0]    stamp;
	} qent_t;

endpackage

>>> rtl/accel_step_detector.sv
// Accelerometer step detector. Each input transaction carries one three-axis
// sample (micro-m/s^2) with local time, capture time and sync baseline; each
// produces exactly one output transaction, with step_found in tuser and
// baseline plus capture time in tdata (zero when no step). A new sample is
// taken every cycle unless the queue is full with stage two holding: two front
// stages square and sum the axes and feed a four-entry queue, and the back
// stage runs the ground/air machine into an output register. The sustained
// rate is one sample per cycle while the output is not stalled, as the phase
// and last-step registers update on every popped sample. Threshold and floor
// registers are in 0.01 m/s^2; their scaled squares pass through a scaling and
// a squaring register after a write, the cooldown in microseconds through its own.
module accel_step_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// accel_x, accel_y, accel_z, local_time_us, capture_time_us, sync_baseline_us
	input  logic [asd_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// step_time_us
	output logic [asd_pkg::OUT_TDATA_W-1:0] m_tdata,
	// step_found
	output logic                            m_tuser,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [asd_pkg::PADDR_W-1:0]     paddr,
	input  logic [asd_pkg::PDATA_W-1:0]     pwdata,
	output logic [asd_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);
	import asd_pkg::*;

	cfg_t  cfg;
	qent_t push_ent;
	qent_t pop_ent;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	asd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	asd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.push     (push),
		.push_ent (push_ent),
		.full     (full)
	);

	asd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.full     (full),
		.pop      (pop),
		.pop_ent  (pop_ent),
		.empty    (empty)
	);

	asd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pop_ent  (pop_ent),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> rtl/asd_cfg.sv
module asd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [asd_pkg::PADDR_W-1:0] paddr,
	input  logic [asd_pkg::PDATA_W-1:0] pwdata,
	output logic [asd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output asd_pkg::cfg_t               cfg
);
	import asd_pkg::*;

	logic [LEVEL_W-1:0]   impact_q;
	logic [LEVEL_W-1:0]   lift_q;
	logic [COOL_W-1:0]    cool_q;
	logic [LIN_W-1:0]     impact_lin_q;
	logic [LIN_W-1:0]     lift_lin_q;
	logic [LVL_SQ_W-1:0]  impact_sq_q;
	logic [LVL_SQ_W-1:0]  lift_sq_q;
	logic [COOL_US_W-1:0] cool_us_q;
	logic                 wen;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wen    = psel & penable & pwrite & pready;
	assign idx    = paddr[PADDR_W-1 -: REG_IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			impact_q <= IMPACT_RESET;
			lift_q   <= LIFT_RESET;
			cool_q   <= COOL_RESET;
		end else if (wen) begin
			case (idx)
				REG_IMPACT: impact_q <= pwdata[LEVEL_W-1:0];
				REG_LIFT:   lift_q   <= pwdata[LEVEL_W-1:0];
				REG_COOL:   cool_q   <= pwdata[COOL_W-1:0];
				default:    ;
			endcase
		end
	end

	// scale the levels, then square the registered scaled values; convert the cooldown to microseconds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			impact_lin_q <= IMPACT_LIN_RESET;
			lift_lin_q   <= LIFT_LIN_RESET;
			impact_sq_q  <= IMPACT_SQ_RESET;
			lift_sq_q    <= LIFT_SQ_RESET;
			cool_us_q    <= COOL_US_RESET;
		end else begin
			impact_lin_q <= LIN_W'(impact_q) * LIN_W'(SCALE_TO_MICRO);
			lift_lin_q   <= LIN_W'(lift_q) * LIN_W'(SCALE_TO_MICRO);
			impact_sq_q  <= LVL_SQ_W'(impact_lin_q) * LVL_SQ_W'(impact_lin_q);
			lift_sq_q    <= LVL_SQ_W'(lift_lin_q) * LVL_SQ_W'(lift_lin_q);
			cool_us_q    <= COOL_US_W'(cool_q) * COOL_US_W'(MICROS_PER_MILLI);
		end
	end

	always_comb begin
		case (idx)
			REG_IMPACT: prdata = PDATA_W'(impact_q);
			REG_LIFT:   prdata = PDATA_W'(lift_q);
			REG_COOL:   prdata = PDATA_W'(cool_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.impact_sq = impact_sq_q;
	assign cfg.lift_sq   = lift_sq_q;
	assign cfg.cool_us   = cool_us_q;

endmodule

>>> rtl/asd_front.sv
module asd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// accel_x, accel_y, accel_z, local_time_us, capture_time_us, sync_baseline_us
	input  logic [asd_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic                           push,
	output asd_pkg::qent_t                 push_ent,
	input  logic                           full
);
	import asd_pkg::*;

	logic                  en;
	logic                  acc;
	logic                  v_s1;
	logic                  v_s2;
	logic [ACCEL_W-1:0]    ax;
	logic [ACCEL_W-1:0]    ay;
	logic [ACCEL_W-1:0]    az;
	logic [ACCEL_W-1:0]    abs_x;
	logic [ACCEL_W-1:0]    abs_y;
	logic [ACCEL_W-1:0]    abs_z;
	logic [SQ1_W-1:0]      sq_x_s1;
	logic [SQ1_W-1:0]      sq_y_s1;
	logic [SQ1_W-1:0]      sq_z_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic [CAP_W-1:0]      cap_s1;
	logic [BASE_W-1:0]     base_s1;
	logic [TIME_WIDTH-1:0] stamp_sum;
	qent_t                 ent_s2;

	assign en       = !(v_s2 && full);
	assign s_tready = en;
	assign acc      = s_tvalid && en;

	assign ax = s_tdata[X_LSB +: ACCEL_W];
	assign ay = s_tdata[Y_LSB +: ACCEL_W];
	assign az = s_tdata[Z_LSB +: ACCEL_W];

	assign abs_x = ax[ACCEL_W-1] ? (~ax + ACCEL_W'(1)) : ax;
	assign abs_y = ay[ACCEL_W-1] ? (~ay + ACCEL_W'(1)) : ay;
	assign abs_z = az[ACCEL_W-1] ? (~az + ACCEL_W'(1)) : az;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s1 <= SQ1_W'(abs_x) * SQ1_W'(abs_x);
			sq_y_s1 <= SQ1_W'(abs_y) * SQ1_W'(abs_y);
			sq_z_s1 <= SQ1_W'(abs_z) * SQ1_W'(abs_z);
			now_s1  <= TIME_WIDTH'(s_tdata[LT_LSB +: LTIME_W]);
			cap_s1  <= s_tdata[CAP_LSB +: CAP_W];
			base_s1 <= s_tdata[BASE_LSB +: BASE_W];
		end
	end

	assign stamp_sum = TIME_WIDTH'(base_s1) + TIME_WIDTH'(cap_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			ent_s2.mag   <= sq_x_s1 + sq_y_s1 + sq_z_s1;
			ent_s2.now   <= now_s1;
			ent_s2.stamp <= STAMP_W'(stamp_sum);
		end
	end

	assign push     = v_s2 && en;
	assign push_ent = ent_s2;

endmodule

>>> rtl/asd_queue.sv
module asd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  asd_pkg::qent_t push_ent,
	output logic           full,
	input  logic           pop,
	output asd_pkg::qent_t pop_ent,
	output logic           empty
);
	import asd_pkg::*;

	qent_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full    = (count_q == (QAW+1)'(QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_ent = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QAW+1)'(1);
				2'b01:   count_q <= count_q - (QAW+1)'(1);
				default: ;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");

endmodule

>>> rtl/asd_back.sv
module asd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  asd_pkg::cfg_t                   cfg,
	input  asd_pkg::qent_t                  pop_ent,
	input  logic                            empty,
	output logic                            pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// step_time_us
	output logic [asd_pkg::OUT_TDATA_W-1:0] m_tdata,
	// step_found
	output logic                            m_tuser
);
	import asd_pkg::*;

	localparam logic ST_GROUND = 1'b0;
	localparam logic ST_AIR    = 1'b1;

	logic                  air_q;
	logic [TIME_WIDTH-1:0] last_q;
	logic                  m_tvalid_q;
	logic                  found_q;
	logic [STAMP_W-1:0]    stamp_q;
	logic [TIME_WIDTH-1:0] elapsed;
	logic                  found;
	logic                  air_n;

	assign pop     = !empty && (!m_tvalid_q || m_tready);
	assign elapsed = pop_ent.now - last_q;

	always_comb begin
		found = 1'b0;
		air_n = air_q;
		case (air_q)
			ST_GROUND: begin
				if (MAG_W'(cfg.lift_sq) > pop_ent.mag) begin
					air_n = ST_AIR;
				end
			end
			ST_AIR: begin
				if (pop_ent.mag > MAG_W'(cfg.impact_sq) &&
						elapsed > TIME_WIDTH'(cfg.cool_us)) begin
					found = 1'b1;
					air_n = ST_GROUND;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_q      <= ST_GROUND;
			last_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				air_q <= air_n;
				if (found) begin
					last_q <= pop_ent.now;
				end
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			found_q <= found;
			stamp_q <= found ? pop_ent.stamp : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = OUT_TDATA_W'(stamp_q);

	a_no_step_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0) else $error("time on non-step");
	a_step_ground: assert property (@(posedge clk) disable iff (!arst_n)
		pop && found |=> air_q == ST_GROUND) else $error("step left air phase");
	a_phase_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(air_q) |-> $past(pop)) else $error("phase moved without transaction");

endmodule

>>> tb/accel_step_detector_tb.sv
`timescale 1ns / 100ps

module accel_step_detector_tb;
	import asd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int RANDOM_PER_PHASE = 131;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_SENDER = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH = 3;

	typedef struct {
		bit        found;
		bit [62:0] stamp;
	} step_report_t;

	class step_tracker;
		bit [LEVEL_W-1:0] impact_lvl;
		bit [LEVEL_W-1:0] lift_lvl;
		bit [COOL_W-1:0]  cool_ms;
		bit               in_air;
		bit [63:0]        last_step_us;
		step_report_t     expected_steps[$];
		int               errors;
		int               samples;
		int               steps;

		function new();
			impact_lvl = IMPACT_RESET;
			lift_lvl = LIFT_RESET;
			cool_ms = COOL_RESET;
			in_air = 1'b0;
			last_step_us = '0;
			errors = 0;
			samples = 0;
			steps = 0;
		endfunction

		function void set_reg(bit [REG_IDX_W-1:0] idx, bit [PDATA_W-1:0] value);
			case (idx)
				REG_IMPACT: impact_lvl = value[LEVEL_W-1:0];
				REG_LIFT: lift_lvl = value[LEVEL_W-1:0];
				REG_COOL: cool_ms = value[COOL_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [63:0] axis_sq(bit [ACCEL_W-1:0] v);
			bit [63:0] ext;
			ext = {{(64 - ACCEL_W){v[ACCEL_W-1]}}, v};
			if (v[ACCEL_W-1]) ext = -ext;
			return ext * ext;
		endfunction

		function bit [63:0] level_sq(bit [LEVEL_W-1:0] lvl);
			bit [63:0] lin;
			lin = 64'(lvl) * SCALE_TO_MICRO;
			return lin * lin;
		endfunction

		function void note_sample(bit [IN_TDATA_W-1:0] d);
			bit [63:0]    mag;
			bit [63:0]    now;
			bit [63:0]    sum;
			step_report_t r;
			mag = axis_sq(d[X_LSB +: ACCEL_W]) + axis_sq(d[Y_LSB +: ACCEL_W])
				+ axis_sq(d[Z_LSB +: ACCEL_W]);
			now = {1'b0, d[LT_LSB +: LTIME_W]};
			r.found = 1'b0;
			r.stamp = '0;
			if (!in_air) begin
				if (mag < level_sq(lift_lvl)) in_air = 1'b1;
			end else if (mag > level_sq(impact_lvl)) begin
				if (now - last_step_us > 64'(cool_ms) * MICROS_PER_MILLI) begin
					sum = {1'b0, d[BASE_LSB +: BASE_W]} + {32'b0, d[CAP_LSB +: CAP_W]};
					r.found = 1'b1;
					r.stamp = sum[62:0];
					in_air = 1'b0;
					last_step_us = now;
					steps++;
				end
			end
			samples++;
			expected_steps.push_back(r);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) $display("mismatch: %s", msg);
		endfunction

		function void check_output(logic found, logic [OUT_TDATA_W-1:0] data);
			step_report_t r;
			if (expected_steps.size() == 0) begin
				flag($sformatf("unexpected result found=%b time=%0d", found, data));
			end else begin
				r = expected_steps.pop_front();
				if (found !== r.found || data !== OUT_TDATA_W'({1'b0, r.stamp}))
					flag($sformatf("expected found=%0d time=%0d, got found=%b time=%0d",
						r.found, r.stamp, found, data));
			end
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [PADDR_W-1:0]     paddr = '0;
	logic [PDATA_W-1:0]     pwdata = '0;
	logic [PDATA_W-1:0]     prdata;
	logic                   pready;

	step_tracker sb;
	int          cycles = 0;
	int          send_idle = 0;
	int          recv_stall = 0;
	int          settings = 1;
	bit [62:0]   now_us = '0;

	accel_step_detector u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[accel_step_detector] ERROR");
			$finish;
		end else begin
			if (arst_n && sb != null && m_tvalid && m_tready)
				sb.check_output(m_tuser, m_tdata);
			m_tready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	task automatic send_sample(bit [ACCEL_W-1:0] x, bit [ACCEL_W-1:0] y,
		bit [ACCEL_W-1:0] z, bit [62:0] lt, bit [31:0] cap, bit [62:0] base);
		bit [IN_TDATA_W-1:0] d;
		d = '0;
		d[X_LSB +: ACCEL_W] = x;
		d[Y_LSB +: ACCEL_W] = y;
		d[Z_LSB +: ACCEL_W] = z;
		d[LT_LSB +: LTIME_W] = lt;
		d[CAP_LSB +: CAP_W] = cap;
		d[BASE_LSB +: BASE_W] = base;
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_sample(d);
	endtask

	task automatic apb_write(bit [REG_IDX_W-1:0] idx, bit [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic rand_axis(output bit [ACCEL_W-1:0] a, input int half);
		a = ACCEL_W'(int'($urandom_range(0, 2 * half)) - half);
	endtask

	task automatic send_random();
		bit [ACCEL_W-1:0] ax[3];
		int               kind;
		int               half;
		int               pick;
		int               peak;
		int               r;
		bit [31:0]        cool_us;
		bit [62:0]        base;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			half = int'(64'(sb.lift_lvl) * SCALE_TO_MICRO / 2);
			for (int i = 0; i < 3; i++) rand_axis(ax[i], half);
		end else if (kind <= 7) begin
			half = int'(64'(sb.impact_lvl) * SCALE_TO_MICRO / 4);
			for (int i = 0; i < 3; i++) rand_axis(ax[i], half);
			pick = $urandom_range(0, 2);
			peak = int'(64'(sb.impact_lvl) * SCALE_TO_MICRO) + int'($urandom_range(1, 1000000));
			ax[pick] = $urandom_range(0, 1) ? ACCEL_W'(peak) : ACCEL_W'(-peak);
		end else begin
			for (int i = 0; i < 3; i++) ax[i] = ACCEL_W'($urandom);
		end
		cool_us = 32'(sb.cool_ms) * 32'(MICROS_PER_MILLI);
		r = $urandom_range(0, 99);
		if (r >= 8) now_us = now_us + 63'($urandom_range(0, cool_us / 3 + 2000));
		else if (r >= 5) now_us = 63'({$urandom, $urandom});
		base = ($urandom_range(0, 9) == 0) ? '1 : 63'({$urandom, $urandom});
		send_sample(ax[0], ax[1], ax[2], now_us, $urandom, base);
	endtask

	task automatic run_directed();
		bit [ACCEL_W-1:0] lift_edge;
		bit [ACCEL_W-1:0] impact_edge;
		bit [ACCEL_W-1:0] pos_max;
		bit [ACCEL_W-1:0] neg_max;
		bit [ACCEL_W-1:0] mid;
		bit [62:0]        t_max;
		lift_edge = ACCEL_W'(64'(LIFT_RESET) * SCALE_TO_MICRO);
		impact_edge = ACCEL_W'(64'(IMPACT_RESET) * SCALE_TO_MICRO);
		pos_max = {1'b0, {(ACCEL_W - 1){1'b1}}};
		neg_max = {1'b1, {(ACCEL_W - 1){1'b0}}};
		mid = ACCEL_W'(10000000);
		t_max = '1;
		send_sample(lift_edge, 0, 0, 63'd1000, 0, 0);
		send_sample(-(lift_edge - ACCEL_W'(1)), 0, 0, 63'd2000, $urandom, 63'd5);
		send_sample(impact_edge, 0, 0, 63'd300000, $urandom, 63'd7);
		send_sample(0, 0, impact_edge + ACCEL_W'(1), 63'd300000, '1, t_max);
		send_sample(0, 0, 0, 63'd301000, 0, 0);
		send_sample(pos_max, 0, 0, 63'd550000, $urandom, 63'd11);
		send_sample(0, neg_max, 0, 63'd550001, $urandom, 63'd13);
		send_sample(0, 0, 0, 63'd600000, 0, t_max);
		send_sample(neg_max, neg_max, neg_max, t_max, '1, 63'd17);
		send_sample(0, 0, 0, t_max, 0, 0);
		send_sample(pos_max, pos_max, pos_max, 63'd5, 0, t_max);
		send_sample(neg_max, 0, 0, 63'h4000_0000_0000_0000, $urandom, 63'd19);
		send_sample(0, 0, 0, 63'h4000_0000_0000_0000, 0, 0);
		send_sample(mid, -mid, 0, 63'h4000_0000_0000_0001, $urandom, 63'd23);
		send_sample(-impact_edge - ACCEL_W'(1), 0, 0, 63'd100, $urandom, 63'd29);
		send_sample(0, impact_edge + ACCEL_W'(1), 0, 63'd250006, $urandom, 63'd31);
		send_sample(0, 0, 0, 63'd260000, $urandom, 63'd37);
		send_sample(0, 0, -impact_edge - ACCEL_W'(1), 63'd500006, $urandom, 63'd41);
		send_sample(0, 0, -impact_edge - ACCEL_W'(1), 63'd500007, 0, 0);
		now_us = 63'd500007;
	endtask

	task automatic apply_settings(int phase);
		case (phase)
			1: begin
				apb_write(REG_IMPACT, 32'd0);
				apb_write(REG_LIFT, 32'hFFFF_FFFF);
				apb_write(REG_COOL, 32'd0);
				apb_write(REG_SPARE, 32'h0000_1234);
			end
			2: begin
				apb_write(REG_IMPACT, 32'd16383);
				apb_write(REG_LIFT, 32'd0);
				apb_write(REG_COOL, 32'hFFFF_FFFF);
			end
			3: begin
				apb_write(REG_IMPACT, 32'd1000);
				apb_write(REG_LIFT, 32'd800);
				apb_write(REG_COOL, 32'd20);
			end
			5: begin
				apb_write(REG_IMPACT, 32'd16000);
				apb_write(REG_LIFT, 32'd16000);
				apb_write(REG_COOL, 32'd65535);
				apb_write(REG_SPARE, $urandom);
			end
			7: begin
				apb_write(REG_IMPACT, 32'd2000);
				apb_write(REG_LIFT, 32'd500);
				apb_write(REG_COOL, 32'd250);
			end
			default: begin
				apb_write(REG_IMPACT, $urandom_range(0, 16383));
				apb_write(REG_LIFT, $urandom_range(0, 16383));
				apb_write(REG_COOL, $urandom_range(0, 300));
			end
		endcase
		settings++;
		repeat (4) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				drain();
				apply_settings(phase);
			end
			case (phase % 4)
				IDLE_NONE: begin
					send_idle = 0;
					recv_stall = 0;
				end
				IDLE_SENDER: begin
					send_idle = 81;
					recv_stall = 0;
				end
				IDLE_RECEIVER: begin
					send_idle = 0;
					recv_stall = 81;
				end
				default: begin
					send_idle = 8;
					recv_stall = 8;
				end
			endcase
			repeat (RANDOM_PER_PHASE) send_random();
		end
		recv_stall = 0;
		drain();
		repeat (16) @(posedge clk);
		$display("covered %0d samples with %0d accepted steps under %0d register settings",
			sb.samples, sb.steps, settings);
		$display("stalls on neither, either and both sides; %0d mismatches", sb.errors);
		if (sb.errors == 0) begin
			$display("[accel_step_detector] OK");
		end else begin
			$display("[accel_step_detector] ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/asd_pkg.sv
rtl/asd_cfg.sv
rtl/asd_front.sv
rtl/asd_queue.sv
rtl/asd_back.sv
rtl/accel_step_detector.sv
tb/accel_step_detector_tb.sv
